[hw/rtl/pewd_pkg.sv]
package pewd_pkg;

    localparam int ACC_W = 48;
    localparam int COEF_W = 32;
    localparam int FRAC_BITS = 16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic signed [ACC_W-1:0] POS48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] NEG48 = -48'sh8000_0000_0000;
    localparam logic [63:0] ROUND_HALF = 64'h8000;

    typedef struct packed {
        logic                     kind;
        logic [5:0]               coeff_index;
        logic signed [COEF_W-1:0] coeff_value;
        logic signed [COEF_W-1:0] x_value;
    } t_cmd;

    typedef struct packed {
        logic signed [ACC_W-1:0] poly_value;
        logic signed [ACC_W-1:0] first_derivative;
        logic signed [ACC_W-1:0] second_derivative;
        logic                    overflow_flag;
    } t_result;

endpackage

[hw/rtl/pewd_rnd_sat.sv]
module pewd_rnd_sat (
    input  logic [62:0]                           i_plo,
    input  logic [46:0]                           i_phi,
    input  logic                                  i_neg,
    output logic signed [pewd_pkg::ACC_W-1:0]     o_mq,
    output logic                                  o_ovf
);

    logic [63:0] w_lo_rnd;
    logic [63:0] w_mag;

    assign w_lo_rnd = (64'(i_plo) + pewd_pkg::ROUND_HALF) >> pewd_pkg::FRAC_BITS;
    assign w_mag = {1'b0, i_phi, 16'b0} + w_lo_rnd;

    always_comb begin
        o_ovf = 1'b0;
        if (i_neg) begin
            if (w_mag > 64'h8000_0000_0000) begin
                o_ovf = 1'b1;
                o_mq = pewd_pkg::NEG48;
            end else begin
                o_mq = -$signed(w_mag[47:0]);
            end
        end else begin
            if (w_mag > 64'h7FFF_FFFF_FFFF) begin
                o_ovf = 1'b1;
                o_mq = pewd_pkg::POS48;
            end else begin
                o_mq = $signed(w_mag[47:0]);
            end
        end
    end

endmodule

[hw/rtl/polynomial_eval_with_derivatives_unit.sv]
// Channel   Handshake                    Payload            Direction
// command   start, busy                  i_cmd (t_cmd)      in
// result    o_done                       o_result           out
// config    i_cfg_valid, o_cfg_ready     i_cfg_data         in
//
// A load transfer writes the coefficient store and leaves busy low.
// After an evaluate transfer busy stays high while the unit works: one fetch per coefficient,
// then five steps per chain term on the one shared 33 by 33 multiplier; the strobe follows and
// a new transfer may end its cycle.
// Reset clears the control state and sets the coefficient count to one.
// The result is shown for one cycle with o_done and stays on o_result until the next evaluate transfer.
module polynomial_eval_with_derivatives_unit #(
    parameter int MAX_TERMS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pewd_pkg::t_cmd        i_cmd,
    output logic                  o_done,
    output pewd_pkg::t_result     o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [6:0]            i_cfg_data
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam int NW = $clog2(MAX_TERMS + 1);
    localparam int FW = 2 * AW;
    localparam int TW = 33 + FW;
    localparam int SW = ((TW > 48) ? TW : 48) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_TERM  = 3'd2;
    localparam logic [2:0] S_MLO   = 3'd3;
    localparam logic [2:0] S_MHI   = 3'd4;
    localparam logic [2:0] S_RND   = 3'd5;
    localparam logic [2:0] S_ACC   = 3'd6;

    localparam logic [1:0] K_POLY = 2'd0;
    localparam logic [1:0] K_D1   = 2'd1;
    localparam logic [1:0] K_D2   = 2'd2;

    logic signed [31:0] r_mem [MAX_TERMS];
    logic signed [31:0] r_rdata;

    logic [2:0]          r_state;
    logic [1:0]          r_k;
    logic [AW-1:0]       r_j;
    logic [FW-1:0]       r_f2;
    logic                r_busy;
    logic                r_done;
    logic                r_ovf;
    logic [6:0]          r_count;
    logic [31:0]         r_xm;
    logic                r_xneg;
    logic [47:0]         r_am;
    logic                r_neg;
    logic [62:0]         r_plo;
    logic [46:0]         r_phi;
    logic signed [47:0]  r_mq;
    logic signed [TW-1:0] r_term;
    logic signed [47:0]  r_acc [3];

    logic                w_accept;
    logic [NW-1:0]       w_n;
    logic [AW-1:0]       w_j0;
    logic [FW-1:0]       w_f2_0;
    logic [FW-1:0]       w_fac;
    logic [47:0]         w_am;
    logic signed [32:0]  w_ma;
    logic signed [32:0]  w_mb;
    logic signed [65:0]  w_mp;
    logic signed [47:0]  w_rnd_mq;
    logic                w_rnd_ovf;
    logic signed [SW-1:0] w_sum;
    logic signed [47:0]  w_sat;
    logic                w_sat_ovf;

    assign w_accept = start && !r_busy;
    assign busy = r_busy;
    assign o_done = r_done;
    assign o_cfg_ready = !r_busy;

    assign o_result.poly_value = r_acc[0];
    assign o_result.first_derivative = r_acc[1];
    assign o_result.second_derivative = r_acc[2];
    assign o_result.overflow_flag = r_ovf;

    always_comb begin
        if (r_count == 7'd0) begin
            w_n = NW'(1);
        end else if (32'(r_count) > 32'(MAX_TERMS)) begin
            w_n = NW'(MAX_TERMS);
        end else begin
            w_n = NW'(r_count);
        end
    end

    assign w_j0 = AW'(w_n - NW'(1));
    assign w_f2_0 = (w_j0 == '0) ? '0 : FW'(FW'(w_j0) * FW'(w_j0 - AW'(1)));

    always_comb begin
        case (r_k)
            K_POLY:  w_fac = FW'(1);
            K_D1:    w_fac = FW'(r_j);
            default: w_fac = r_f2;
        endcase
    end

    assign w_am = r_acc[r_k][47] ? 48'(-r_acc[r_k]) : r_acc[r_k];

    always_comb begin
        case (r_state)
            S_MLO: begin
                w_ma = {1'b0, r_am[31:0]};
                w_mb = {1'b0, r_xm};
            end
            S_MHI: begin
                w_ma = {17'b0, r_am[47:32]};
                w_mb = {1'b0, r_xm};
            end
            default: begin
                w_ma = 33'(r_rdata);
                w_mb = $signed(33'(w_fac));
            end
        endcase
    end

    assign w_mp = w_ma * w_mb;

    pewd_rnd_sat u_rnd_sat (
        .i_plo (r_plo),
        .i_phi (r_phi),
        .i_neg (r_neg),
        .o_mq  (w_rnd_mq),
        .o_ovf (w_rnd_ovf)
    );

    assign w_sum = SW'(r_mq) + SW'(r_term);

    always_comb begin
        w_sat_ovf = 1'b0;
        if (w_sum > SW'(pewd_pkg::POS48)) begin
            w_sat_ovf = 1'b1;
            w_sat = pewd_pkg::POS48;
        end else if (w_sum < SW'(pewd_pkg::NEG48)) begin
            w_sat_ovf = 1'b1;
            w_sat = pewd_pkg::NEG48;
        end else begin
            w_sat = w_sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_cmd.kind == pewd_pkg::KIND_LOAD
                && 32'(i_cmd.coeff_index) < 32'(MAX_TERMS)) begin
            r_mem[AW'(i_cmd.coeff_index)] <= i_cmd.coeff_value;
        end
        r_rdata <= r_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_TERM: begin
                r_term <= w_mp[TW-1:0];
                r_am <= w_am;
                r_neg <= r_acc[r_k][47] ^ r_xneg;
            end
            S_MLO: r_plo <= w_mp[62:0];
            S_MHI: r_phi <= w_mp[46:0];
            S_RND: r_mq <= w_rnd_mq;
            default: begin
            end
        endcase
        if (w_accept && i_cmd.kind == pewd_pkg::KIND_EVAL) begin
            r_xneg <= i_cmd.x_value[31];
            r_xm <= i_cmd.x_value[31] ? 32'(-i_cmd.x_value) : i_cmd.x_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k <= K_POLY;
            r_j <= '0;
            r_f2 <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf <= 1'b0;
            r_count <= 7'd1;
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_cmd.kind == pewd_pkg::KIND_EVAL) begin
                        r_state <= S_FETCH;
                        r_busy <= 1'b1;
                        r_k <= K_POLY;
                        r_j <= w_j0;
                        r_f2 <= w_f2_0;
                        r_ovf <= 1'b0;
                        r_acc[0] <= '0;
                        r_acc[1] <= '0;
                        r_acc[2] <= '0;
                    end
                end
                S_FETCH: r_state <= S_TERM;
                S_TERM:  r_state <= S_MLO;
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_RND;
                S_RND: begin
                    r_ovf <= r_ovf | w_rnd_ovf;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_k] <= w_sat;
                    r_ovf <= r_ovf | w_sat_ovf;
                    if (r_k == K_POLY && r_j == '0) begin
                        r_state <= S_IDLE;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else if (r_k == K_POLY
                            || (r_k == K_D1 && r_j > AW'(1))) begin
                        r_k <= r_k + 2'd1;
                        r_state <= S_TERM;
                    end else begin
                        r_k <= K_POLY;
                        r_j <= r_j - AW'(1);
                        r_f2 <= r_f2 - FW'({r_j - AW'(1), 1'b0});
                        r_state <= S_FETCH;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !busy)
        else $error("Result strobe while busy.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done)
        else $error("Result strobe longer than one cycle.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind == pewd_pkg::KIND_EVAL) |=> busy)
        else $error("Evaluate transfer did not start the sequencer.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind == pewd_pkg::KIND_LOAD) |=> (!busy && !o_done))
        else $error("Load transfer disturbed the sequencer.");

endmodule

[tb/polynomial_eval_with_derivatives_unit_test.sv]
`timescale 1ns / 100ps

module polynomial_eval_with_derivatives_unit_test;

    localparam int STORE_DEPTH = 64;
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_LIMIT = 10;
    localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_8000_0000_0000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    pewd_pkg::t_cmd     i_cmd = '0;
    logic               o_done;
    pewd_pkg::t_result  o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [6:0]         i_cfg_data = '0;

    logic signed [pewd_pkg::COEF_W-1:0] coeff_store [STORE_DEPTH];
    bit                                 coeff_written [STORE_DEPTH];
    logic [6:0]                         term_count = 7'd1;
    bit                                 horner_sat;
    pewd_pkg::t_result                  pending_results [$];
    int                                 mismatch_count = 0;
    int                                 sender_idle_pct = 0;
    int                                 quiet_cycles = 0;

    polynomial_eval_with_derivatives_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp48(input longint v);
        if (v > SAT_HI) begin
            horner_sat = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            horner_sat = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // Exact product, rounded half away from zero on the magnitude, then saturated.
    function automatic longint scale_mul(input longint acc, input longint x);
        bit          neg;
        logic [63:0] am;
        logic [63:0] xm;
        logic [63:0] r;
        logic [95:0] prod;
        neg = (acc < 0) != (x < 0);
        am = (acc < 0) ? -acc : acc;
        xm = (x < 0) ? -x : x;
        prod = {32'd0, am} * {32'd0, xm};
        prod = prod + 96'h8000;
        r = prod[79:16];
        if (neg) begin
            if (r > 64'h0000_8000_0000_0000) begin
                horner_sat = 1'b1;
                return SAT_LO;
            end
            return -$signed(r);
        end
        if (r > 64'h0000_7FFF_FFFF_FFFF) begin
            horner_sat = 1'b1;
            return SAT_HI;
        end
        return $signed(r);
    endfunction

    function automatic int effective_terms(input logic [6:0] setting);
        if (setting == 0) return 1;
        if (setting > STORE_DEPTH) return STORE_DEPTH;
        return int'(setting);
    endfunction

    function automatic pewd_pkg::t_result horner_eval(
            input logic signed [pewd_pkg::COEF_W-1:0] x_in);
        longint            x;
        longint            c;
        longint            y;
        longint            dy;
        longint            d2y;
        int                n;
        pewd_pkg::t_result res;
        horner_sat = 1'b0;
        x = x_in;
        n = effective_terms(term_count);
        c = coeff_store[n-1];
        y = c;
        dy = clamp48(c * (n - 1));
        d2y = (n >= 2) ? clamp48(c * ((n - 1) * (n - 2))) : 64'sd0;
        for (int i = n - 2; i >= 0; i--) begin
            c = coeff_store[i];
            y = clamp48(scale_mul(y, x) + c);
            if (i > 0) dy = clamp48(scale_mul(dy, x) + c * i);
            if (i > 1) d2y = clamp48(scale_mul(d2y, x) + c * (i * (i - 1)));
        end
        res.poly_value = y[pewd_pkg::ACC_W-1:0];
        res.first_derivative = dy[pewd_pkg::ACC_W-1:0];
        res.second_derivative = d2y[pewd_pkg::ACC_W-1:0];
        res.overflow_flag = horner_sat;
        return res;
    endfunction

    function automatic logic signed [pewd_pkg::COEF_W-1:0] q16_value();
        logic signed [pewd_pkg::COEF_W-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(7))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0001_0000;
                    4: v = 32'hFFFF_0000;
                    5: v = 32'h0000_0001;
                    6: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_8000;
                endcase
            end
            1, 2, 3, 4, 5: v = int'($urandom_range(262143)) - 131072;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic pewd_pkg::t_cmd make_load(
            input int idx, input logic signed [pewd_pkg::COEF_W-1:0] val);
        pewd_pkg::t_cmd cmd;
        cmd.kind = pewd_pkg::KIND_LOAD;
        cmd.coeff_index = idx[5:0];
        cmd.coeff_value = val;
        cmd.x_value = $urandom;
        return cmd;
    endfunction

    function automatic pewd_pkg::t_cmd make_eval(input logic signed [pewd_pkg::COEF_W-1:0] x);
        pewd_pkg::t_cmd cmd;
        cmd.kind = pewd_pkg::KIND_EVAL;
        cmd.coeff_index = 6'($urandom_range(63));
        cmd.coeff_value = $urandom;
        cmd.x_value = x;
        return cmd;
    endfunction

    // Start is left high after a transfer so that back-to-back items need no extra edge.
    task automatic issue_command(input pewd_pkg::t_cmd cmd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
        if (cmd.kind == pewd_pkg::KIND_LOAD) begin
            if (cmd.coeff_index < STORE_DEPTH) begin
                coeff_store[cmd.coeff_index] = cmd.coeff_value;
                coeff_written[cmd.coeff_index] = 1'b1;
            end
        end else begin
            pending_results.push_back(horner_eval(cmd.x_value));
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [6:0] setting);
        settle();
        while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        term_count = setting;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_coefficients();
        int n;
        n = effective_terms(term_count);
        for (int i = 0; i < n; i++) begin
            if (!coeff_written[i]) issue_command(make_load(i, q16_value()));
        end
    endtask

    task automatic test_reset_count_and_extremes();
        issue_command(make_load(0, 32'h7FFF_FFFF));
        issue_command(make_eval(32'h0000_0000));
        issue_command(make_eval(32'h8000_0000));
        issue_command(make_load(63, 32'h8000_0000));
    endtask

    task automatic test_rounding_ties();
        write_count(7'd2);
        issue_command(make_load(1, 32'h0000_0001));
        issue_command(make_load(0, 32'h0000_0000));
        issue_command(make_eval(32'h0000_8000));
        issue_command(make_load(1, 32'hFFFF_FFFF));
        issue_command(make_eval(32'h0000_8000));
        issue_command(make_eval(32'hFFFF_8000));
    endtask

    task automatic test_saturation();
        write_count(7'd3);
        issue_command(make_load(2, 32'h8000_0000));
        issue_command(make_load(1, 32'h7FFF_FFFF));
        issue_command(make_eval(32'h7FFF_FFFF));
        issue_command(make_eval(32'h8000_0000));
        issue_command(make_eval(32'h0001_0000));
        issue_command(make_eval(32'hFFFF_0000));
    endtask

    task automatic test_count_clamping();
        write_count(7'd0);
        issue_command(make_eval(32'h1234_5678));
        issue_command(make_eval(32'hEDCB_A988));
    endtask

    task automatic test_random_traffic(input int idle_pct, input logic [6:0] first_setting);
        logic [6:0] setting;
        int         n;
        int         eval_pct;
        sender_idle_pct = idle_pct;
        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                setting = first_setting;
            end else begin
                case ($urandom_range(19))
                    0: setting = 7'd0;
                    1: setting = 7'd127;
                    2: setting = 7'd1;
                    3, 4, 5, 6, 7, 8, 9, 10: setting = 7'($urandom_range(2, 8));
                    11, 12, 13, 14, 15, 16: setting = 7'($urandom_range(9, 24));
                    default: setting = 7'($urandom_range(25, 64));
                endcase
            end
            write_count(setting);
            n = effective_terms(setting);
            eval_pct = (n > 32) ? 30 : 55;
            fill_coefficients();
            for (int k = 0; k < 150; k++) begin
                if ($urandom_range(99) < eval_pct) begin
                    issue_command(make_eval(q16_value()));
                end else if ($urandom_range(99) < 80) begin
                    issue_command(make_load(int'($urandom_range(n - 1)), q16_value()));
                end else begin
                    issue_command(make_load(int'($urandom_range(63)), q16_value()));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        pewd_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result: %h %h %h %b", o_result.poly_value,
                             o_result.first_derivative, o_result.second_derivative,
                             o_result.overflow_flag);
            end else begin
                want = pending_results.pop_front();
                if (o_result.poly_value !== want.poly_value ||
                    o_result.first_derivative !== want.first_derivative ||
                    o_result.second_derivative !== want.second_derivative ||
                    o_result.overflow_flag !== want.overflow_flag) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Mismatch at %0t: expected p=%h d1=%h d2=%h ovf=%b", $time,
                                 want.poly_value, want.first_derivative,
                                 want.second_derivative, want.overflow_flag);
                        $display("                 actual   p=%h d1=%h d2=%h ovf=%b",
                                 o_result.poly_value, o_result.first_derivative,
                                 o_result.second_derivative, o_result.overflow_flag);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("Timeout with %0d results outstanding.", pending_results.size());
            $display("FAIL polynomial_eval_with_derivatives_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            coeff_store[i] = '0;
            coeff_written[i] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_count_and_extremes();
        test_rounding_ties();
        test_saturation();
        test_count_clamping();
        test_random_traffic(0, 7'd127);
        test_random_traffic(65, 7'd64);
        test_random_traffic(23, 7'd65);
        settle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS polynomial_eval_with_derivatives_unit");
        end else begin
            $display("FAIL polynomial_eval_with_derivatives_unit");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pewd_pkg.sv
hw/rtl/pewd_rnd_sat.sv
hw/rtl/polynomial_eval_with_derivatives_unit.sv
tb/polynomial_eval_with_derivatives_unit_test.sv
